@@ hw/rtl/pkse_pkg.sv @@
package pkse_pkg;

   localparam int ACTION_WIDTH        = 3;
   localparam int KEY_WIDTH           = 32;
   localparam int POS_WIDTH           = 8;
   localparam int STATUS_WIDTH        = 2;
   localparam int COUNT_WIDTH         = 6;
   localparam int DEFAULT_STACK_DEPTH = 32;

   // stream payload widths, padded to whole bytes
   localparam int REQ_TDATA_WIDTH = 56;
   localparam int RSP_TDATA_WIDTH = 16;

   // action codes, five to seven do nothing
   localparam logic [ACTION_WIDTH-1:0] ACT_INSERT = 3'd0;
   localparam logic [ACTION_WIDTH-1:0] ACT_DELETE = 3'd1;
   localparam logic [ACTION_WIDTH-1:0] ACT_SWAP   = 3'd2;
   localparam logic [ACTION_WIDTH-1:0] ACT_COUNT  = 3'd3;
   localparam logic [ACTION_WIDTH-1:0] ACT_SEARCH = 3'd4;

   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_BAD_POS   = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      CS_IDLE,
      CS_DISPATCH,
      CS_FIND,
      CS_SHIFT_UP,
      CS_PLACE,
      CS_SHIFT_DOWN,
      CS_SWAP_RD,
      CS_SWAP_WR_A,
      CS_SWAP_WR_B,
      CS_FINISH
   } state_type;

   typedef enum logic [3:0] {
      DP_NONE,
      DP_LOAD,
      DP_FIND,
      DP_SHIFT_UP,
      DP_PLACE,
      DP_SHIFT_DOWN,
      DP_SWAP_RD,
      DP_SWAP_WR_A,
      DP_SWAP_WR_B,
      DP_FINISH
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      status_type status;
   } dp_cmd_type;

   typedef struct packed {
      logic [ACTION_WIDTH-1:0] action;
      logic                    full;
      logic                    bad_pos;
      logic                    find_hit;
      logic                    find_miss;
      logic                    up_done;
      logic                    down_done;
   } dp_stat_type;

endpackage

@@ hw/rtl/pkse_ctrl.sv @@
module pkse_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  pkse_pkg::dp_stat_type stat,
   output pkse_pkg::dp_cmd_type  cmd
);
   import pkse_pkg::*;

   state_type  state_ff, state_in;
   status_type status_ff, status_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CS_IDLE;
         status_ff    <= ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         status_ff    <= status_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      req_tready   = 1'b0;
      cmd.op       = DP_NONE;
      cmd.status   = status_ff;
      case (state_ff)
         CS_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.op   = DP_LOAD;
               state_in = CS_DISPATCH;
            end
         end
         CS_DISPATCH: begin
            status_in = ST_OK;
            state_in  = CS_FINISH;
            if (stat.action == ACT_INSERT) begin
               if (stat.full) begin
                  status_in = ST_FULL;
               end else begin
                  state_in = CS_SHIFT_UP;
               end
            end else if (stat.action inside {ACT_DELETE, ACT_SEARCH}) begin
               state_in = CS_FIND;
            end else if (stat.action == ACT_SWAP) begin
               if (stat.bad_pos) begin
                  status_in = ST_BAD_POS;
               end else begin
                  state_in = CS_SWAP_RD;
               end
            end
         end
         CS_FIND: begin
            cmd.op = DP_FIND;
            if (stat.find_hit) begin
               status_in = ST_OK;
               state_in  = (stat.action == ACT_DELETE) ? CS_SHIFT_DOWN : CS_FINISH;
            end else if (stat.find_miss) begin
               status_in = ST_NOT_FOUND;
               state_in  = CS_FINISH;
            end
         end
         CS_SHIFT_UP: begin
            cmd.op = DP_SHIFT_UP;
            if (stat.up_done) begin
               state_in = CS_PLACE;
            end
         end
         CS_PLACE: begin
            cmd.op   = DP_PLACE;
            state_in = CS_FINISH;
         end
         CS_SHIFT_DOWN: begin
            cmd.op = DP_SHIFT_DOWN;
            if (stat.down_done) begin
               state_in = CS_FINISH;
            end
         end
         CS_SWAP_RD: begin
            cmd.op   = DP_SWAP_RD;
            state_in = CS_SWAP_WR_A;
         end
         CS_SWAP_WR_A: begin
            cmd.op   = DP_SWAP_WR_A;
            state_in = CS_SWAP_WR_B;
         end
         CS_SWAP_WR_B: begin
            cmd.op   = DP_SWAP_WR_B;
            state_in = CS_FINISH;
         end
         CS_FINISH: begin
            // wait here while the previous response is still stalled
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.op       = DP_FINISH;
               rsp_valid_in = 1'b1;
               state_in     = CS_IDLE;
            end
         end
         default: begin
            state_in = CS_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

@@ hw/rtl/pkse_dp.sv @@
module pkse_dp #(
   parameter int STACK_DEPTH = pkse_pkg::DEFAULT_STACK_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  pkse_pkg::dp_cmd_type                cmd,
   output pkse_pkg::dp_stat_type               stat,
   input  logic [pkse_pkg::ACTION_WIDTH-1:0]   req_action,
   input  logic signed [pkse_pkg::KEY_WIDTH-1:0] req_key,
   input  logic [pkse_pkg::POS_WIDTH-1:0]      req_position_a,
   input  logic [pkse_pkg::POS_WIDTH-1:0]      req_position_b,
   output pkse_pkg::status_type                rsp_status,
   output logic [pkse_pkg::COUNT_WIDTH-1:0]    rsp_entry_count,
   output logic [pkse_pkg::COUNT_WIDTH-1:0]    rsp_match_position
);
   import pkse_pkg::*;

   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CW = $clog2(STACK_DEPTH + 1);

   logic signed [KEY_WIDTH-1:0] mem [STACK_DEPTH];

   logic [CW-1:0]               count_ff, count_in;
   logic [CW-1:0]               idx_ff, idx_in;
   logic                        probe_ff, probe_in;
   logic [CW-1:0]               probe_pos_ff, probe_pos_in;
   logic [CW-1:0]               match_ff, match_in;
   logic [CW-1:0]               slot_ff, slot_in;
   logic [ACTION_WIDTH-1:0]     action_ff, action_in;
   logic signed [KEY_WIDTH-1:0] key_ff, key_in;
   logic [AW-1:0]               addr_a_ff, addr_a_in;
   logic [AW-1:0]               addr_b_ff, addr_b_in;
   logic                        full_ff, full_in;
   logic                        bad_ff, bad_in;
   logic signed [KEY_WIDTH-1:0] rd_data_ff, rd2_data_ff;
   status_type                  rsp_status_ff, rsp_status_in;
   logic [COUNT_WIDTH-1:0]      rsp_count_ff, rsp_count_in;
   logic [COUNT_WIDTH-1:0]      rsp_match_ff, rsp_match_in;

   logic                        rd_en;
   logic [AW-1:0]               rd_addr, rd2_addr;
   logic                        wr_en;
   logic [AW-1:0]               wr_addr;
   logic signed [KEY_WIDTH-1:0] wr_data;
   logic [POS_WIDTH-1:0]        cnt_ext, match_ext;
   logic                        hit, miss, up_done, down_done;

   // stack storage, two read ports and one write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff  <= mem[rd_addr];
         rd2_data_ff <= mem[rd2_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         probe_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         probe_ff <= probe_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      probe_pos_ff  <= probe_pos_in;
      match_ff      <= match_in;
      slot_ff       <= slot_in;
      action_ff     <= action_in;
      key_ff        <= key_in;
      addr_a_ff     <= addr_a_in;
      addr_b_ff     <= addr_b_in;
      full_ff       <= full_in;
      bad_ff        <= bad_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_match_ff  <= rsp_match_in;
   end

   assign cnt_ext   = POS_WIDTH'(count_ff);
   assign match_ext = POS_WIDTH'(match_ff);
   assign hit       = probe_ff && (rd_data_ff == key_ff);
   assign miss      = !probe_ff && (idx_ff == '0);
   assign up_done   = !probe_ff && (idx_ff <= slot_ff);
   assign down_done = !probe_ff && (idx_ff >= count_ff);

   always_comb begin
      count_in      = count_ff;
      idx_in        = idx_ff;
      probe_in      = 1'b0;
      probe_pos_in  = probe_pos_ff;
      match_in      = match_ff;
      slot_in       = slot_ff;
      action_in     = action_ff;
      key_in        = key_ff;
      addr_a_in     = addr_a_ff;
      addr_b_in     = addr_b_ff;
      full_in       = full_ff;
      bad_in        = bad_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_match_in  = rsp_match_ff;
      rd_en         = 1'b0;
      rd_addr       = '0;
      rd2_addr      = '0;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = key_ff;
      case (cmd.op)
         DP_LOAD: begin
            action_in = req_action;
            key_in    = req_key;
            idx_in    = count_ff;
            match_in  = '0;
            full_in   = (count_ff == CW'(STACK_DEPTH));
            bad_in    = (req_position_a == '0) || (req_position_b == '0) ||
                        (req_position_a == req_position_b) ||
                        (req_position_a > cnt_ext) || (req_position_b > cnt_ext);
            addr_a_in = AW'(req_position_a - POS_WIDTH'(1));
            addr_b_in = AW'(req_position_b - POS_WIDTH'(1));
            // position zero means bottom, beyond the count means top
            if (req_position_a == '0) begin
               slot_in = '0;
            end else if (req_position_a > cnt_ext) begin
               slot_in = count_ff;
            end else begin
               slot_in = CW'(req_position_a - POS_WIDTH'(1));
            end
         end
         DP_FIND: begin
            // walk from the top, compare in the cycle after the read
            if (hit) begin
               match_in = probe_pos_ff;
               idx_in   = probe_pos_ff;
            end else if (idx_ff != '0) begin
               rd_en        = 1'b1;
               rd_addr      = AW'(idx_ff - CW'(1));
               probe_in     = 1'b1;
               probe_pos_in = idx_ff;
               idx_in       = idx_ff - CW'(1);
            end
         end
         DP_SHIFT_UP: begin
            if (probe_ff) begin
               wr_en   = 1'b1;
               wr_addr = AW'(probe_pos_ff);
               wr_data = rd_data_ff;
            end
            if (idx_ff > slot_ff) begin
               rd_en        = 1'b1;
               rd_addr      = AW'(idx_ff - CW'(1));
               probe_in     = 1'b1;
               probe_pos_in = idx_ff;
               idx_in       = idx_ff - CW'(1);
            end
         end
         DP_PLACE: begin
            wr_en    = 1'b1;
            wr_addr  = AW'(slot_ff);
            wr_data  = key_ff;
            count_in = count_ff + CW'(1);
         end
         DP_SHIFT_DOWN: begin
            if (probe_ff) begin
               wr_en   = 1'b1;
               wr_addr = AW'(probe_pos_ff);
               wr_data = rd_data_ff;
            end
            if (idx_ff < count_ff) begin
               rd_en        = 1'b1;
               rd_addr      = AW'(idx_ff);
               probe_in     = 1'b1;
               probe_pos_in = idx_ff - CW'(1);
               idx_in       = idx_ff + CW'(1);
            end
            if (down_done) begin
               count_in = count_ff - CW'(1);
            end
         end
         DP_SWAP_RD: begin
            rd_en    = 1'b1;
            rd_addr  = addr_a_ff;
            rd2_addr = addr_b_ff;
         end
         DP_SWAP_WR_A: begin
            wr_en   = 1'b1;
            wr_addr = addr_a_ff;
            wr_data = rd2_data_ff;
         end
         DP_SWAP_WR_B: begin
            wr_en   = 1'b1;
            wr_addr = addr_b_ff;
            wr_data = rd_data_ff;
         end
         DP_FINISH: begin
            rsp_status_in = cmd.status;
            rsp_count_in  = cnt_ext[COUNT_WIDTH-1:0];
            rsp_match_in  = match_ext[COUNT_WIDTH-1:0];
         end
         default: begin
         end
      endcase
   end

   assign stat.action    = action_ff;
   assign stat.full      = full_ff;
   assign stat.bad_pos   = bad_ff;
   assign stat.find_hit  = hit;
   assign stat.find_miss = miss;
   assign stat.up_done   = up_done;
   assign stat.down_done = down_done;

   assign rsp_status         = rsp_status_ff;
   assign rsp_entry_count    = rsp_count_ff;
   assign rsp_match_position = rsp_match_ff;

endmodule

@@ hw/rtl/positional_key_stack_engine.sv @@
// channel | dir | ports                  | content
// req     | in  | req_tvalid/tready/tdata | action, key, position_a, position_b
// rsp     | out | rsp_tvalid/tready/tdata | status, entry_count, match_position
//
// steps per request: count, full insert and bad swap go from dispatch to finish;
// swap reads both entries, writes a, then writes b; insert moves the entries above
// the slot up, then places the key; search walks from the top one entry a cycle
// and stops on a hit or at the bottom; delete then moves the entries above the match down
// reset clears the entry count and control, not the stored keys
// a stalled response holds in its register and holds the next request at its end
module positional_key_stack_engine #(
   parameter int STACK_DEPTH = pkse_pkg::DEFAULT_STACK_DEPTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // req_tdata: action [2:0], key [34:3], position_a [42:35],
   // position_b [50:43], zero fill [55:51]
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [pkse_pkg::REQ_TDATA_WIDTH-1:0] req_tdata,
   // rsp_tdata: status [1:0], entry_count [7:2], match_position [13:8],
   // zero fill [15:14]
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [pkse_pkg::RSP_TDATA_WIDTH-1:0] rsp_tdata
);
   import pkse_pkg::*;

   dp_cmd_type                  cmd;
   dp_stat_type                 stat;
   logic [ACTION_WIDTH-1:0]     req_action;
   logic signed [KEY_WIDTH-1:0] req_key;
   logic [POS_WIDTH-1:0]        req_position_a;
   logic [POS_WIDTH-1:0]        req_position_b;
   status_type                  rsp_status;
   logic [COUNT_WIDTH-1:0]      rsp_entry_count;
   logic [COUNT_WIDTH-1:0]      rsp_match_position;

   // unpack request fields
   assign req_action     = req_tdata[2:0];
   assign req_key        = req_tdata[34:3];
   assign req_position_a = req_tdata[42:35];
   assign req_position_b = req_tdata[50:43];

   // controller: sequences each action and owns the response valid
   pkse_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // datapath: key memory, walk counters, compare and response register
   pkse_dp #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_action         (req_action),
      .req_key            (req_key),
      .req_position_a     (req_position_a),
      .req_position_b     (req_position_b),
      .rsp_status         (rsp_status),
      .rsp_entry_count    (rsp_entry_count),
      .rsp_match_position (rsp_match_position)
   );

   // pack response fields, lowest first
   assign rsp_tdata = {2'b00, rsp_match_position, rsp_entry_count, rsp_status};

   // a taken request makes the block busy on the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while a transaction is in process");

   // a miss never reports a match position
   a_miss_no_match: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[1:0] == ST_NOT_FOUND)) |-> (rsp_tdata[13:8] == '0))
      else $error("key not found response carries a match position");

   // full is only reported with the stack at its depth
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[1:0] == ST_FULL)) |->
      (rsp_tdata[7:2] == COUNT_WIDTH'(STACK_DEPTH)))
      else $error("stack full response with a count below the depth");

   // only a swap gives bad position, and it carries no match position
   a_bad_pos_no_match: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[1:0] == ST_BAD_POS)) |-> (rsp_tdata[13:8] == '0))
      else $error("bad position response carries a match position");

endmodule
